### hw/rtl/smalu_pkg.sv
// ----------------------------------------------------------------------------
// smalu_pkg
// types and codes shared by the stack-machine alu modules
// ----------------------------------------------------------------------------
`default_nettype none
package smalu_pkg;

    localparam int KIND_W   = 4;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 7;
    localparam int FIELD_W  = 64;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH = 4'd0,
        K_ADD  = 4'd1,
        K_SUB  = 4'd2,
        K_DIV  = 4'd3,
        K_MUL  = 4'd4,
        K_AND  = 4'd5,
        K_OR   = 4'd6,
        K_XOR  = 4'd7,
        K_NOT  = 4'd8,
        K_SHL  = 4'd9,
        K_SHR  = 4'd10
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_CAPB,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_WRITE,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic  load_req;
        logic  rd_second;
        logic  cap_a;
        logic  cap_b;
        logic  mul_start;
        logic  mul_step;
        logic  div_start;
        logic  div_step;
        logic  div_fin;
        logic  wr_en;
        logic  sp_inc;
        logic  sp_dec;
        logic  out_load;
        status_t status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  sp_zero;
        logic  sp_lt2;
        logic  sp_full;
        logic  b_zero;
        logic  mul_done;
        logic  div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/smalu_ram.sv
// ----------------------------------------------------------------------------
// smalu_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module smalu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### hw/rtl/smalu_ctrl.sv
// ----------------------------------------------------------------------------
// smalu_ctrl
// sequencer for one stack instruction
// ----------------------------------------------------------------------------
`default_nettype none
module smalu_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire smalu_pkg::dp_stat_t   stat,
    output smalu_pkg::ctrl_cmd_t       cmd
);

    smalu_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smalu_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == smalu_pkg::S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.status     = smalu_pkg::ST_OK;
        case (state_reg)
            smalu_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = smalu_pkg::S_RDA;
                end
            end
            smalu_pkg::S_RDA:
            begin
                case (stat.kind)
                    smalu_pkg::K_PUSH:
                    begin
                        if (stat.sp_full)
                        begin
                            cmd.status   = smalu_pkg::ST_OVER;
                            state_next   = smalu_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.sp_inc = 1'b1;
                            state_next = smalu_pkg::S_WRITE;
                        end
                    end
                    smalu_pkg::K_NOT:
                    begin
                        if (stat.sp_zero)
                        begin
                            cmd.status   = smalu_pkg::ST_UNDER;
                            state_next   = smalu_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = smalu_pkg::S_RDB;
                        end
                    end
                    smalu_pkg::K_ADD, smalu_pkg::K_SUB, smalu_pkg::K_DIV,
                    smalu_pkg::K_MUL, smalu_pkg::K_AND, smalu_pkg::K_OR,
                    smalu_pkg::K_XOR, smalu_pkg::K_SHL, smalu_pkg::K_SHR:
                    begin
                        if (stat.sp_lt2)
                        begin
                            cmd.status   = smalu_pkg::ST_UNDER;
                            state_next   = smalu_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = smalu_pkg::S_RDB;
                        end
                    end
                    default:
                    begin
                        state_next   = smalu_pkg::S_DONE;
                    end
                endcase
            end
            smalu_pkg::S_RDB:
            begin
                cmd.cap_a = 1'b1;
                if (stat.kind == smalu_pkg::K_NOT)
                begin
                    state_next = smalu_pkg::S_EXEC;
                end
                else
                begin
                    cmd.rd_second = 1'b1;
                    state_next    = smalu_pkg::S_CAPB;
                end
            end
            smalu_pkg::S_CAPB:
            begin
                cmd.cap_b = 1'b1;
                state_next = smalu_pkg::S_EXEC;
            end
            smalu_pkg::S_EXEC:
            begin
                case (stat.kind)
                    smalu_pkg::K_NOT:
                    begin
                        cmd.wr_en  = 1'b1;
                        state_next = smalu_pkg::S_WRITE;
                    end
                    smalu_pkg::K_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            cmd.status   = smalu_pkg::ST_DIVZERO;
                            state_next   = smalu_pkg::S_WRITE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = smalu_pkg::S_DIV;
                        end
                    end
                    smalu_pkg::K_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = smalu_pkg::S_MUL;
                    end
                    default:
                    begin
                        cmd.sp_dec = 1'b1;
                        cmd.wr_en  = 1'b1;
                        state_next = smalu_pkg::S_WRITE;
                    end
                endcase
            end
            smalu_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    cmd.sp_dec = 1'b1;
                    cmd.wr_en  = 1'b1;
                    state_next = smalu_pkg::S_WRITE;
                end
            end
            smalu_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = smalu_pkg::S_DIVFIN;
                end
            end
            smalu_pkg::S_DIVFIN:
            begin
                cmd.div_fin = 1'b1;
                cmd.sp_dec  = 1'b1;
                cmd.wr_en   = 1'b1;
                state_next  = smalu_pkg::S_WRITE;
            end
            smalu_pkg::S_WRITE:
            begin
                state_next   = smalu_pkg::S_DONE;
            end
            smalu_pkg::S_DONE:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = smalu_pkg::S_IDLE;
            end
            default:
            begin
                state_next = smalu_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/smalu_dp.sv
// ----------------------------------------------------------------------------
// smalu_dp
// stack pointer, operand registers, alu, serial multiplier and divider
// ----------------------------------------------------------------------------
`default_nettype none
module smalu_dp #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [smalu_pkg::KIND_W-1:0] kind,
    input  wire logic                        is_unsigned,
    input  wire logic [smalu_pkg::FIELD_W-1:0] immediate,
    input  wire smalu_pkg::ctrl_cmd_t        cmd,
    output smalu_pkg::dp_stat_t              stat,
    output logic [smalu_pkg::FIELD_W-1:0]    top_value,
    output logic [smalu_pkg::DEPTH_W-1:0]    stack_depth,
    output logic [smalu_pkg::STATUS_W-1:0]   status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(VALUE_WIDTH + 1);
    localparam int MB  = 8;
    localparam int MSTEPS = (VALUE_WIDTH + MB - 1) / MB;

    logic [SPW-1:0]         sp_reg, sp_next;
    logic [3:0]             kind_reg;
    logic                   uns_reg;
    logic [VALUE_WIDTH-1:0] imm_reg;
    logic [VALUE_WIDTH-1:0] a_reg, b_reg, r_next;
    logic [VALUE_WIDTH-1:0] acc_reg, mb_reg;
    logic [VALUE_WIDTH-1:0] q_reg, rem_reg, dvs_reg;
    logic                   qneg_reg;
    logic [CW-1:0]          cnt_reg;
    logic [VALUE_WIDTH-1:0] top_reg;
    logic [SPW-1:0]         depth_reg;
    logic [1:0]             status_reg;

    logic [AW-1:0]          ram_addr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    smalu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_comb
    begin
        sp_next = sp_reg;
        if (cmd.sp_inc)
        begin
            sp_next = sp_reg + SPW'(1);
        end
        else if (cmd.sp_dec)
        begin
            sp_next = sp_reg - SPW'(1);
        end
    end

    always_comb
    begin
        ram_addr = AW'(sp_reg - SPW'(1));
        if ((kind_reg == smalu_pkg::K_PUSH) && cmd.wr_en)
        begin
            ram_addr = AW'(sp_reg);
        end
        else if (cmd.rd_second || (cmd.wr_en && cmd.sp_dec))
        begin
            ram_addr = AW'(sp_reg - SPW'(2));
        end
    end

    assign stat.kind     = smalu_pkg::kind_t'(kind_reg);
    assign stat.sp_zero  = (sp_reg == '0);
    assign stat.sp_lt2   = (sp_reg < SPW'(2));
    assign stat.sp_full  = (sp_reg == SPW'(STACK_DEPTH));
    assign stat.b_zero   = (b_reg == '0);
    assign stat.mul_done = (cnt_reg == CW'(MSTEPS - 1));
    assign stat.div_done = (cnt_reg == CW'(VALUE_WIDTH - 1));

    // alu for the combinational operations
    logic                   big_cnt;
    logic [CW-1:0]          sh;
    logic                   neg_a;
    always_comb
    begin
        big_cnt = (b_reg > VALUE_WIDTH'(VALUE_WIDTH - 1));
        sh      = CW'(b_reg);
        neg_a   = !uns_reg && a_reg[VALUE_WIDTH-1];
        case (kind_reg)
            smalu_pkg::K_ADD: r_next = a_reg + b_reg;
            smalu_pkg::K_SUB: r_next = a_reg - b_reg;
            smalu_pkg::K_AND: r_next = a_reg & b_reg;
            smalu_pkg::K_OR:  r_next = a_reg | b_reg;
            smalu_pkg::K_XOR: r_next = a_reg ^ b_reg;
            smalu_pkg::K_NOT: r_next = ~a_reg;
            smalu_pkg::K_SHL: r_next = big_cnt ? '0 : (a_reg << sh);
            smalu_pkg::K_SHR:
            begin
                if (big_cnt)
                begin
                    r_next = {VALUE_WIDTH{neg_a}};
                end
                else
                begin
                    r_next = VALUE_WIDTH'($signed({neg_a, a_reg}) >>> sh);
                end
            end
            default: r_next = a_reg;
        endcase
    end

    logic [VALUE_WIDTH-1:0] ma, mbd, rem_sh, rem_sub;
    logic                   rem_ge;
    logic [VALUE_WIDTH-1:0] part;
    always_comb
    begin
        ma  = (!uns_reg && a_reg[VALUE_WIDTH-1]) ? -a_reg : a_reg;
        mbd = (!uns_reg && b_reg[VALUE_WIDTH-1]) ? -b_reg : b_reg;
        rem_sh  = {rem_reg[VALUE_WIDTH-2:0], q_reg[VALUE_WIDTH-1]};
        rem_ge  = rem_reg[VALUE_WIDTH-1] || (rem_sh >= dvs_reg);
        rem_sub = rem_sh - dvs_reg;
        part = VALUE_WIDTH'(a_reg * mb_reg[MB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg <= kind;
            uns_reg  <= is_unsigned;
            imm_reg  <= VALUE_WIDTH'(immediate);
        end
        if (cmd.load_req)
        begin
            status_reg <= smalu_pkg::ST_OK;
        end
        else if (cmd.status != smalu_pkg::ST_OK)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.cap_a)
        begin
            a_reg <= ram_rdata;
        end
        if (cmd.cap_b)
        begin
            b_reg <= ram_rdata;
        end
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            mb_reg  <= b_reg;
            cnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= acc_reg + (VALUE_WIDTH'(part[VALUE_WIDTH-1:0])
                                  << (cnt_reg * CW'(MB)));
            mb_reg  <= mb_reg >> MB;
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.div_start)
        begin
            q_reg    <= ma;
            dvs_reg  <= mbd;
            rem_reg  <= '0;
            qneg_reg <= !uns_reg && (a_reg[VALUE_WIDTH-1] != b_reg[VALUE_WIDTH-1]);
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sub : rem_sh;
            q_reg   <= {q_reg[VALUE_WIDTH-2:0], rem_ge};
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.div_fin)
        begin
            q_reg <= qneg_reg ? -q_reg : q_reg;
        end
        if (cmd.out_load)
        begin
            depth_reg  <= sp_reg;
            top_reg    <= (sp_reg == '0) ? '0 : ram_rdata;
        end
    end

    // write data: push immediate, combinational alu, multiplier or divider
    always_comb
    begin
        case (kind_reg)
            smalu_pkg::K_PUSH: ram_wdata = imm_reg;
            smalu_pkg::K_MUL:  ram_wdata = acc_reg + (VALUE_WIDTH'(part[VALUE_WIDTH-1:0])
                                           << (cnt_reg * CW'(MB)));
            smalu_pkg::K_DIV:  ram_wdata = qneg_reg ? -q_reg : q_reg;
            default:           ram_wdata = r_next;
        endcase
    end

    assign top_value   = smalu_pkg::FIELD_W'(top_reg);
    assign stack_depth = smalu_pkg::DEPTH_W'(depth_reg);
    assign status      = status_reg;

endmodule
`default_nettype wire

### hw/rtl/stack_machine_integer_alu.sv
// ----------------------------------------------------------------------------
// stack_machine_integer_alu
// push writes the immediate, not and two-operand kinds read their operands before writing back;
// refused requests and spare kinds go straight to the result; multiply and divide run serially
// one request at a time, next accepted the cycle after the result is taken
// ----------------------------------------------------------------------------
`default_nettype none
module stack_machine_integer_alu #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  kind,
    input  wire logic        is_unsigned,
    input  wire logic [63:0] immediate,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      top_value,
    output logic [6:0]       stack_depth,
    output logic [1:0]       status
);

    smalu_pkg::ctrl_cmd_t cmd;
    smalu_pkg::dp_stat_t  stat;

    smalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    smalu_dp #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .is_unsigned (is_unsigned),
        .immediate   (immediate),
        .cmd         (cmd),
        .stat        (stat),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .status      (status)
    );

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request accepted while result pending");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stack_depth <= 7'(STACK_DEPTH)))
        else $error("stack depth beyond capacity");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_depth == 7'd0) |-> (top_value == 64'd0))
        else $error("empty stack shows nonzero top");

endmodule
`default_nettype wire
